FILE: rtl/core/skr_pkg.sv
// ----------------------------------------------------------------------------
// skr_pkg
// Shared types and constants for the six-key rollover report buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package skr_pkg;

  // Key list depth default and the fixed width of the report
  localparam int unsigned SlotsDefault = 6;
  localparam int unsigned ReportKeys   = 6;
  localparam int unsigned KeyW         = 8;
  localparam int unsigned CmdW         = 2;
  localparam int unsigned HeldW        = 3;

  // Command codes; code 3 is unused and leaves the state alone
  typedef enum logic [CmdW-1:0] {
    CmdPress   = 2'd0,
    CmdRelease = 2'd1,
    CmdPoll    = 2'd2
  } cmd_e;

  // One input item
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [KeyW-1:0] key_code;
    logic            host_ready;
  } key_item_t;

  // One result item
  typedef struct packed {
    logic             report_sent;
    logic [KeyW-1:0]  slot_0;
    logic [KeyW-1:0]  slot_1;
    logic [KeyW-1:0]  slot_2;
    logic [KeyW-1:0]  slot_3;
    logic [KeyW-1:0]  slot_4;
    logic [KeyW-1:0]  slot_5;
    logic [HeldW-1:0] held_count;
    logic             pending_change;
  } key_report_t;

  // Status from the update logic
  typedef struct packed {
    logic sent;
    logic changed;
  } upd_flags_t;

endpackage

`default_nettype wire

FILE: rtl/core/skr_in_stage.sv
// ----------------------------------------------------------------------------
// skr_in_stage
// Input register: holds one accepted item until the update stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module skr_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  skr_pkg::key_item_t in_item_i,
  input  logic              take_i,
  output logic              valid_o,
  output skr_pkg::key_item_t item_o
);

  logic               vld_q, vld_d;
  skr_pkg::key_item_t item_q;

  // Free when empty or when the held item leaves this cycle
  assign in_ready_o = !vld_q || take_i;

  always_comb begin
    vld_d = vld_q;
    if (in_valid_i && in_ready_o) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

FILE: rtl/core/skr_update.sv
// ----------------------------------------------------------------------------
// skr_update
// Next-state logic of the key list: press, release with shift-down, poll.
// ----------------------------------------------------------------------------
`default_nettype none

module skr_update #(
  parameter int unsigned Slots = skr_pkg::SlotsDefault,
  localparam int unsigned CntW = $clog2(Slots + 1)
) (
  input  skr_pkg::key_item_t       item_i,
  input  logic [skr_pkg::KeyW-1:0] slots_i [Slots],
  input  logic [CntW-1:0]          count_i,
  input  logic                     flag_i,
  output logic [skr_pkg::KeyW-1:0] slots_o [Slots],
  output logic [CntW-1:0]          count_o,
  output skr_pkg::upd_flags_t      flags_o
);

  localparam int unsigned KeyW = skr_pkg::KeyW;

  logic [Slots-1:0]          match;
  logic [Slots-1:0]          shift_en;
  logic [(Slots+1)*KeyW-1:0] flat;
  logic                      hit;
  logic                      nonzero;
  logic                      full;

  // Compare against all held slots; entries past the count are zero
  always_comb begin
    nonzero = item_i.key_code != '0;
    flat    = '0;
    for (int i = 0; i < Slots; i++) begin
      match[i]              = (slots_i[i] == item_i.key_code) && (CntW'(i) < count_i);
      flat[i*KeyW +: KeyW]  = slots_i[i];
    end
    hit = |match;
    // Everything from the first match upward moves down one place
    shift_en[0] = match[0];
    for (int i = 1; i < Slots; i++) begin
      shift_en[i] = shift_en[i-1] | match[i];
    end
    full = count_i == CntW'(Slots);
  end

  // Apply the command
  always_comb begin
    slots_o         = slots_i;
    count_o         = count_i;
    flags_o.sent    = 1'b0;
    flags_o.changed = flag_i;
    case (item_i.cmd)
      skr_pkg::CmdPress: begin
        if (nonzero && !hit && !full) begin
          for (int i = 0; i < Slots; i++) begin
            if (count_i == CntW'(i)) begin
              slots_o[i] = item_i.key_code;
            end
          end
          count_o         = count_i + CntW'(1);
          flags_o.changed = 1'b1;
        end
      end
      skr_pkg::CmdRelease: begin
        if (nonzero && hit) begin
          // Slot above the top is zero, so the freed slot zero-fills
          for (int i = 0; i < Slots; i++) begin
            if (shift_en[i]) begin
              slots_o[i] = flat[(i+1)*KeyW +: KeyW];
            end
          end
          count_o         = count_i - CntW'(1);
          flags_o.changed = 1'b1;
        end
      end
      skr_pkg::CmdPoll: begin
        if (flag_i && item_i.host_ready) begin
          flags_o.sent    = 1'b1;
          flags_o.changed = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/six_key_rollover_report_buffer.sv
// ----------------------------------------------------------------------------
// six_key_rollover_report_buffer
// Ordered list of held keycodes with a change flag, built as a keyboard
// report on every item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_ready_o   | in_item_i  (key_item_t)
//  out     | output    | out_valid_o / out_ready_i | out_item_o (key_report_t)
//
//  One item per cycle sustained while results are taken; an accepted item
//  passes the input register, then the result register. The key list, count
//  and flag are updated in one pass of the compare and shift logic per item.
//  Reset clears the list, count, flag and both valid bits; no clearing pass.
//  A stalled result holds the input register; input is taken again as soon
//  as the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module six_key_rollover_report_buffer #(
  parameter int unsigned Slots = skr_pkg::SlotsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  skr_pkg::key_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output skr_pkg::key_report_t out_item_o
);

  localparam int unsigned CntW       = $clog2(Slots + 1);
  localparam int unsigned KeyW       = skr_pkg::KeyW;
  localparam int unsigned ReportKeys = skr_pkg::ReportKeys;

  logic                 stage_vld;
  skr_pkg::key_item_t   stage_item;
  logic                 advance;

  logic [KeyW-1:0]      slots_q [Slots];
  logic [KeyW-1:0]      slots_d [Slots];
  logic [CntW-1:0]      count_q, count_d;
  logic                 flag_q;
  skr_pkg::upd_flags_t  upd;

  logic [KeyW-1:0]      rep_key [ReportKeys];
  logic [CntW+2:0]      cnt_ext;
  skr_pkg::key_report_t out_q, out_d;
  logic                 out_vld_q, out_vld_d;

  // Result register free or draining
  assign advance = stage_vld && (!out_vld_q || out_ready_i);

  skr_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .take_i     (advance),
    .valid_o    (stage_vld),
    .item_o     (stage_item)
  );

  skr_update #(
    .Slots (Slots)
  ) u_update (
    .item_i  (stage_item),
    .slots_i (slots_q),
    .count_i (count_q),
    .flag_i  (flag_q),
    .slots_o (slots_d),
    .count_o (count_d),
    .flags_o (upd)
  );

  // Key list state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        slots_q[i] <= '0;
      end
      count_q <= '0;
      flag_q  <= 1'b0;
    end else if (advance) begin
      slots_q <= slots_d;
      count_q <= count_d;
      flag_q  <= upd.changed;
    end
  end

  // Report slots; missing slots read as zero
  for (genvar g = 0; g < ReportKeys; g++) begin : g_rep
    if (g < Slots) begin : g_live
      assign rep_key[g] = slots_d[g];
    end else begin : g_pad
      assign rep_key[g] = '0;
    end
  end

  assign cnt_ext = {3'b000, count_d};

  always_comb begin
    out_d.report_sent    = upd.sent;
    out_d.slot_0         = rep_key[0];
    out_d.slot_1         = rep_key[1];
    out_d.slot_2         = rep_key[2];
    out_d.slot_3         = rep_key[3];
    out_d.slot_4         = rep_key[4];
    out_d.slot_5         = rep_key[5];
    out_d.held_count     = cnt_ext[2:0];
    out_d.pending_change = upd.changed;
  end

  // Result register
  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // Checks
  a_sent_clears_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && upd.sent |=> !flag_q)
    else $error("flag still set after a sent report");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Slots))
    else $error("held count above list depth");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(count_q) && $stable(flag_q))
    else $error("list state moved without an item");

  a_sent_not_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.report_sent && out_item_o.pending_change))
    else $error("report sent while change still pending");

endmodule

`default_nettype wire

FILE: test/key_report_checker.sv
// ----------------------------------------------------------------------------
// key_report_checker
// Watches both channels of the key report buffer. It keeps its own held-key
// list and change flag, works out the report for every accepted key item,
// and compares each returned report field by field, in order.
// ----------------------------------------------------------------------------
module key_report_checker import skr_pkg::*; #(
  parameter int unsigned Slots = SlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        key_valid_i,
  input  logic        key_ready_i,
  input  key_item_t   key_item_i,
  input  logic        rep_valid_i,
  input  logic        rep_ready_i,
  input  key_report_t rep_item_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned reports_o,
  output int unsigned full_drops_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumFields = 9;
  localparam int unsigned MaxShown  = 10;

  // Shadow of the key list and the change flag
  logic [KeyW-1:0] held_keys [Slots];
  int unsigned     held_n;
  logic            report_due;

  key_report_t     expected_reports [$];
  int unsigned     mismatches;
  int unsigned     reports_sent;
  int unsigned     full_drops;

  string field_name [NumFields] = '{"report_sent", "slot_0", "slot_1", "slot_2",
                                    "slot_3", "slot_4", "slot_5", "held_count",
                                    "pending_change"};

  // Apply one key item to the shadow list and build the report it returns
  function automatic key_report_t predict_report(key_item_t it);
    key_report_t     r;
    logic            sent;
    int unsigned     hit;
    int unsigned     i;
    logic [KeyW-1:0] shown [ReportKeys];
    sent = 1'b0;
    hit  = Slots;
    for (i = 0; i < held_n; i++) begin
      if (hit == Slots && held_keys[i] == it.key_code) hit = i;
    end
    case (it.cmd)
      CmdPress: begin
        if (it.key_code != '0 && hit == Slots) begin
          if (held_n < Slots) begin
            held_keys[held_n] = it.key_code;
            held_n++;
            report_due = 1'b1;
          end else begin
            full_drops++;
          end
        end
      end
      CmdRelease: begin
        // close the gap, zero the freed tail slot
        if (it.key_code != '0 && hit < Slots) begin
          for (i = hit; i + 1 < held_n; i++) held_keys[i] = held_keys[i + 1];
          held_n--;
          held_keys[held_n] = '0;
          report_due = 1'b1;
        end
      end
      CmdPoll: begin
        if (report_due && it.host_ready) begin
          report_due = 1'b0;
          sent = 1'b1;
          reports_sent++;
        end
      end
      default: ;
    endcase
    for (i = 0; i < ReportKeys; i++) begin
      if (i < Slots) shown[i] = held_keys[i];
      else shown[i] = '0;
    end
    r = key_report_t'{report_sent: sent, slot_0: shown[0], slot_1: shown[1],
                      slot_2: shown[2], slot_3: shown[3], slot_4: shown[4],
                      slot_5: shown[5], held_count: HeldW'(held_n),
                      pending_change: report_due};
    return r;
  endfunction

  function automatic void split_fields(input key_report_t r,
                                       output logic [KeyW-1:0] f [NumFields]);
    f[0] = KeyW'(r.report_sent);
    f[1] = r.slot_0;
    f[2] = r.slot_1;
    f[3] = r.slot_2;
    f[4] = r.slot_3;
    f[5] = r.slot_4;
    f[6] = r.slot_5;
    f[7] = KeyW'(r.held_count);
    f[8] = KeyW'(r.pending_change);
  endfunction

  // Result side is handled before the input side so that a report can never
  // be matched against an item taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    key_report_t     want;
    logic [KeyW-1:0] want_f [NumFields];
    logic [KeyW-1:0] got_f [NumFields];
    bit              bad;
    int unsigned     i;
    if (!rst_ni) begin
      for (i = 0; i < Slots; i++) held_keys[i] = '0;
      held_n     = 0;
      report_due = 1'b0;
      expected_reports.delete();
    end else begin
      if (rep_valid_i && rep_ready_i) begin
        if (expected_reports.size() == 0) begin
          if (mismatches < MaxShown)
            $display("%0t: report arrived with none outstanding: %p", $realtime, rep_item_i);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          split_fields(want, want_f);
          split_fields(rep_item_i, got_f);
          bad = 1'b0;
          for (i = 0; i < NumFields; i++) begin
            if (got_f[i] !== want_f[i]) begin
              if (mismatches < MaxShown)
                $display("%0t: %s expected %0h got %0h", $realtime, field_name[i],
                         want_f[i], got_f[i]);
              bad = 1'b1;
            end
          end
          if (bad) mismatches++;
        end
      end
      if (key_valid_i && key_ready_i) expected_reports.push_back(predict_report(key_item_i));
    end
    errors_o     = mismatches;
    pending_o    = expected_reports.size();
    reports_o    = reports_sent;
    full_drops_o = full_drops;
  end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives key press, release and poll items into the six-key rollover report
// buffer: a directed pass over the corner cases, then random key sessions
// over small code pools, with random gaps and result back-pressure. The
// checker beside the block judges every report; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import skr_pkg::*;

  localparam logic [CmdW-1:0] CmdUnused  = 2'd3;
  localparam int unsigned     ItemTarget = 1025;
  localparam int unsigned     IdleLimit  = 2000;
  localparam int unsigned     SettleCyc  = 8;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        key_valid;
  logic        key_ready;
  key_item_t   key_item;
  logic        rep_valid;
  logic        rep_ready;
  key_report_t rep_item;

  int unsigned errors;
  int unsigned pending;
  int unsigned reports;
  int unsigned full_drops;

  int unsigned n_press, n_release, n_poll, n_other;
  int unsigned counted;
  bit          burst_mode;
  int unsigned idle_cycles;

  always #5 clk = ~clk;

  six_key_rollover_report_buffer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (key_valid),
    .in_ready_o (key_ready),
    .in_item_i  (key_item),
    .out_valid_o(rep_valid),
    .out_ready_i(rep_ready),
    .out_item_o (rep_item)
  );

  key_report_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .key_valid_i (key_valid),
    .key_ready_i (key_ready),
    .key_item_i  (key_item),
    .rep_valid_i (rep_valid),
    .rep_ready_i (rep_ready),
    .rep_item_i  (rep_item),
    .errors_o    (errors),
    .pending_o   (pending),
    .reports_o   (reports),
    .full_drops_o(full_drops)
  );

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Offer one item, hold it until taken, then maybe idle
  task automatic drive_key(input logic [CmdW-1:0] cmd, input logic [KeyW-1:0] code,
                           input logic ready);
    bit          took;
    int unsigned gap;
    key_item  <= key_item_t'{cmd: cmd, key_code: code, host_ready: ready};
    key_valid <= 1'b1;
    do begin
      @(negedge clk);
      took = key_ready;
      @(posedge clk);
    end while (!took);
    case (cmd)
      CmdPress:   n_press++;
      CmdRelease: n_release++;
      CmdPoll:    n_poll++;
      default:    n_other++;
    endcase
    gap = burst_mode ? 0 : pick_gap();
    if (gap != 0) begin
      key_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every outstanding report is back
  task automatic drain_reports();
    key_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Result side: ready runs broken by random stalls, sometimes long free runs
  initial begin : report_sink
    int unsigned run_len;
    int unsigned stall_len;
    rep_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) run_len = $urandom_range(50, 200);
      else run_len = $urandom_range(1, 12);
      rep_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall_len = pick_gap();
      if (stall_len != 0) begin
        rep_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Ends the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((key_valid && key_ready) || (rep_valid && rep_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout: no item moved for %0d cycles", IdleLimit);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : key_source
    logic [KeyW-1:0]   pool [10];
    int unsigned       pool_n;
    int unsigned       ep_len;
    int unsigned       press_w;
    int unsigned       r;
    int unsigned       k;
    int unsigned       i;
    bit                paused;
    logic [CmdW-1:0]   cmd;
    logic [KeyW-1:0]   code;
    logic              ready;
    int unsigned       total_err;
    rst_n       = 1'b0;
    key_valid   = 1'b0;
    key_item    = '0;
    idle_cycles = 0;
    burst_mode  = 1'b0;
    paused      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners
    drive_key(CmdPoll,    8'h00, 1'b1);  // poll with nothing changed
    drive_key(CmdPress,   8'h00, 1'b1);  // zero keycode press
    drive_key(CmdRelease, 8'h00, 1'b0);  // zero keycode release
    drive_key(CmdPress,   8'hFF, 1'b0);
    drive_key(CmdPress,   8'h01, 1'b1);
    drive_key(CmdPress,   8'hFF, 1'b1);  // duplicate
    drive_key(CmdPress,   8'h80, 1'b0);
    drive_key(CmdPress,   8'h7F, 1'b1);
    drive_key(CmdPress,   8'h55, 1'b0);
    drive_key(CmdPress,   8'hAA, 1'b1);  // list now full
    drive_key(CmdPress,   8'h04, 1'b1);  // dropped, no room
    drive_key(CmdPoll,    8'hFF, 1'b0);  // host not ready
    drive_key(CmdPoll,    8'h00, 1'b1);  // report goes out
    drive_key(CmdPoll,    8'h00, 1'b1);  // nothing new
    drive_key(CmdRelease, 8'h33, 1'b1);  // key not held
    drive_key(CmdRelease, 8'h01, 1'b0);  // middle entry, tail shifts
    drive_key(CmdRelease, 8'hAA, 1'b1);  // last entry
    drive_key(CmdUnused,  8'hFF, 1'b1);
    drive_key(CmdRelease, 8'hFF, 1'b1);  // first entry
    drive_key(CmdPoll,    8'hFF, 1'b1);
    drive_key(CmdRelease, 8'h80, 1'b0);
    drive_key(CmdRelease, 8'h7F, 1'b1);
    drive_key(CmdRelease, 8'h55, 1'b1);  // list empty again
    drive_key(CmdRelease, 8'h55, 1'b0);  // release on an empty list
    drive_key(CmdPoll,    8'h00, 1'b1);
    drain_reports();

    // Random key sessions over a small pool so duplicates, full lists and
    // matching releases come up often
    counted = 0;
    while (counted < ItemTarget) begin
      if (!paused && counted >= ItemTarget / 2) begin
        drain_reports();
        paused = 1'b1;
      end
      pool_n = $urandom_range(3, 10);
      for (i = 0; i < pool_n; i++) pool[i] = KeyW'($urandom_range(1, 255));
      ep_len     = $urandom_range(20, 60);
      press_w    = $urandom_range(30, 60);
      burst_mode = ($urandom_range(0, 4) == 0);
      for (k = 0; k < ep_len && counted < ItemTarget; k++) begin
        r     = $urandom_range(0, 99);
        code  = pool[$urandom_range(0, pool_n - 1)];
        ready = ($urandom_range(0, 3) != 0);
        if (r < press_w) begin
          cmd = CmdPress;
        end else if (r < press_w + 25) begin
          cmd = CmdRelease;
        end else if (r < 94) begin
          cmd = CmdPoll;
          code = KeyW'($urandom_range(0, 255));
        end else begin
          // noise: unused command, zero keycode, or a stray release
          case ($urandom_range(0, 2))
            0: begin
              cmd  = CmdUnused;
              code = KeyW'($urandom_range(0, 255));
            end
            1: begin
              cmd  = $urandom_range(0, 1) ? CmdPress : CmdRelease;
              code = '0;
            end
            default: begin
              cmd  = CmdRelease;
              code = KeyW'($urandom_range(1, 255));
            end
          endcase
        end
        drive_key(cmd, code, ready);
        counted++;
      end
    end
    burst_mode = 1'b0;
    drain_reports();
    repeat (SettleCyc) @(posedge clk);

    total_err = errors;
    if (pending != 0) begin
      $display("%0d reports never arrived", pending);
      total_err++;
    end
    $display("Drove %0d key items: %0d press, %0d release, %0d poll, %0d unused command",
             n_press + n_release + n_poll + n_other, n_press, n_release, n_poll, n_other);
    $display("Host took %0d reports; %0d presses were dropped on a full list",
             reports, full_drops);
    if (total_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
